// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tnm_pkg.sv -----
package tnm_pkg;

    localparam int MAX_INPUTS_DEF = 64;
    localparam int FIFO_DEPTH     = 2;

    typedef enum logic [3:0] {
        MODE_LOAD_W  = 4'd0,
        MODE_LOAD_B  = 4'd1,
        MODE_FWD     = 4'd2,
        MODE_ADD_D   = 4'd3,
        MODE_CLR_D   = 4'd4,
        MODE_W_GRAD  = 4'd5,
        MODE_B_GRAD  = 4'd6,
        MODE_UPD_W   = 4'd7,
        MODE_UPD_B   = 4'd8,
        MODE_DERIV   = 4'd9,
        MODE_READ_W  = 4'd10,
        MODE_NOP     = 4'd15
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FWD   = 2'd0,
        KIND_DERIV = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    localparam logic [1:0] CFG_ACT  = 2'd0;
    localparam logic [1:0] CFG_RATE = 2'd1;
    localparam logic [1:0] CFG_CNT  = 2'd2;

    // Back end sequencer: every op takes the same path, idle, read, multiply, then write.
    typedef enum logic [2:0] {
        BE_IDLE,
        BE_READ,
        BE_MUL,
        BE_WRITE,
        BE_EMIT
    } be_state_t;

    // Decoded word handed from front to back.
    typedef struct packed {
        mode_t        mode;
        logic [5:0]   index;
        logic [15:0]  value;
        logic         last;
        logic         in_store;
    } cmd_t;

    typedef struct packed {
        logic         empty;
        logic         full;
    } q_stat_t;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767)
            sat16 = 16'sh7fff;
        else if (v < -34'sd32768)
            sat16 = 16'sh8000;
        else
            sat16 = v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    // PLAN sigmoid, Q16.16 in, Q8.8 out (0..256).
    function automatic logic [15:0] plan(input logic signed [31:0] x);
        logic [31:0] m;
        logic [31:0] y;
        m = x[31] ? (32'd0 - x) : x;
        if (m >= 32'd327680)
            y = 32'd65536;
        else if (m >= 32'd155648)
            y = (m >> 5) + 32'd55296;
        else if (m >= 32'd65536)
            y = (m >> 3) + 32'd40960;
        else
            y = (m >> 2) + 32'd32768;
        if (x[31])
            y = 32'd65536 - y;
        plan = {8'd0, y[15:8]} | (y[16] ? 16'd256 : 16'd0);
    endfunction

endpackage

// ----- hw/rtl/trainable_neuron_mac_top.sv -----
// Channel   Direction  Handshake               Word
// command   in         start & !busy           mode, index, value, last
// result    out        result_valid strobe     kind, result_value, weighted_sum, size_error
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// Each command steps through the back end in order (pop, store read, multiply,
// write/emit); the shared multiplier and the single store port set this.
// The 2-deep command queue lets the front take words while the back works.
// Reset clears control, bias, delta, gradients and store valid bits at once.
// The receiver cannot stall: a result shows for exactly one cycle.
module trainable_neuron_mac_top #(
    parameter int MAX_INPUTS = tnm_pkg::MAX_INPUTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         mode,
    input  logic [5:0]         index,
    input  logic signed [15:0] value,
    input  logic               last,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic signed [15:0] result_value,
    output logic signed [31:0] weighted_sum,
    output logic               size_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // configuration registers
    logic        act_reg;
    logic [15:0] rate_reg;
    logic [6:0]  cnt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            rate_reg <= 16'd655;
            cnt_reg  <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tnm_pkg::CFG_ACT:  act_reg  <= cfg_data[0];
                tnm_pkg::CFG_RATE: rate_reg <= cfg_data;
                tnm_pkg::CFG_CNT:  cnt_reg  <= cfg_data[6:0];
                default:           act_reg  <= act_reg;
            endcase
        end
    end

    tnm_pkg::cmd_t    push_cmd, head;
    tnm_pkg::q_stat_t q_stat;
    logic             push, pop;

    tnm_front #(.MAX_INPUTS(MAX_INPUTS)) u_front (
        .start(start), .mode(mode), .index(index),
        .value(value), .last(last), .q_stat(q_stat), .busy(busy),
        .push(push), .push_cmd(push_cmd)
    );

    tnm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd),
        .pop(pop), .head(head), .q_stat(q_stat)
    );

    // registered result strobe and payload
    logic               done;
    logic [1:0]         k_c;
    logic signed [15:0] r_c;
    logic signed [31:0] w_c;
    logic               e_c;

    tnm_back #(.MAX_INPUTS(MAX_INPUTS)) u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .q_stat(q_stat), .pop(pop),
        .act_sel(act_reg), .rate(rate_reg), .in_cnt(cnt_reg),
        .done(done), .kind(k_c), .result_value(r_c), .weighted_sum(w_c),
        .size_error(e_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= done;
    end

    always_ff @(posedge clk)
    begin
        kind         <= k_c;
        result_value <= r_c;
        weighted_sum <= w_c;
        size_error   <= e_c;
    end

endmodule

// ----- hw/rtl/tnm_front.sv -----
module tnm_front #(
    parameter int MAX_INPUTS = tnm_pkg::MAX_INPUTS_DEF
) (
    input  logic              start,
    input  logic [3:0]        mode,
    input  logic [5:0]        index,
    input  logic signed [15:0] value,
    input  logic              last,
    input  tnm_pkg::q_stat_t  q_stat,
    output logic              busy,
    output logic              push,
    output tnm_pkg::cmd_t     push_cmd
);

    logic accept;

    assign busy   = q_stat.full;
    assign accept = start && !busy;

    always_comb
    begin
        push_cmd.index    = index;
        push_cmd.value    = value;
        push_cmd.last     = last;
        push_cmd.in_store = ({26'd0, index} < 32'(MAX_INPUTS));
        case (mode)
            tnm_pkg::MODE_LOAD_W: push_cmd.mode = tnm_pkg::MODE_LOAD_W;
            tnm_pkg::MODE_LOAD_B: push_cmd.mode = tnm_pkg::MODE_LOAD_B;
            tnm_pkg::MODE_FWD:    push_cmd.mode = tnm_pkg::MODE_FWD;
            tnm_pkg::MODE_ADD_D:  push_cmd.mode = tnm_pkg::MODE_ADD_D;
            tnm_pkg::MODE_CLR_D:  push_cmd.mode = tnm_pkg::MODE_CLR_D;
            tnm_pkg::MODE_W_GRAD: push_cmd.mode = tnm_pkg::MODE_W_GRAD;
            tnm_pkg::MODE_B_GRAD: push_cmd.mode = tnm_pkg::MODE_B_GRAD;
            tnm_pkg::MODE_UPD_W:  push_cmd.mode = tnm_pkg::MODE_UPD_W;
            tnm_pkg::MODE_UPD_B:  push_cmd.mode = tnm_pkg::MODE_UPD_B;
            tnm_pkg::MODE_DERIV:  push_cmd.mode = tnm_pkg::MODE_DERIV;
            tnm_pkg::MODE_READ_W: push_cmd.mode = tnm_pkg::MODE_READ_W;
            default:              push_cmd.mode = tnm_pkg::MODE_NOP;
        endcase
    end

    // unused modes are dropped here
    assign push = accept && (push_cmd.mode != tnm_pkg::MODE_NOP);

endmodule

// ----- hw/rtl/tnm_queue.sv -----
module tnm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tnm_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output tnm_pkg::cmd_t     head,
    output tnm_pkg::q_stat_t  q_stat
);

    tnm_pkg::cmd_t mem_reg [tnm_pkg::FIFO_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign head         = mem_reg[rp_reg];
    assign q_stat.empty = (cnt_reg == 2'd0);
    assign q_stat.full  = (cnt_reg == 2'(tnm_pkg::FIFO_DEPTH));

endmodule

// ----- hw/rtl/tnm_back.sv -----
module tnm_back #(
    parameter int MAX_INPUTS = tnm_pkg::MAX_INPUTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tnm_pkg::cmd_t      head,
    input  tnm_pkg::q_stat_t   q_stat,
    output logic               pop,
    input  logic               act_sel,
    input  logic [15:0]        rate,
    input  logic [6:0]         in_cnt,
    output logic               done,
    output logic [1:0]         kind,
    output logic signed [15:0] result_value,
    output logic signed [31:0] weighted_sum,
    output logic               size_error
);

    localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    // Weight and gradient stores; valid bits give the zero reset.
    logic signed [15:0] w_mem [MAX_INPUTS];
    logic signed [31:0] g_mem [MAX_INPUTS];
    logic [MAX_INPUTS-1:0] wv_reg, gv_reg;

    logic signed [15:0] bias_reg, delta_reg;
    logic signed [31:0] bgrad_reg, acc_reg;
    logic [6:0]         ecnt_reg;

    tnm_pkg::be_state_t st_reg, st_next;
    tnm_pkg::cmd_t      cmd_reg;
    logic signed [15:0] wrd_reg;
    logic signed [31:0] grd_reg;
    logic signed [47:0] prod_reg, prod_next;

    logic [AW-1:0] addr;
    assign addr = AW'(cmd_reg.index);

    always_ff @(posedge clk)
    begin
        if (st_reg == tnm_pkg::BE_READ)
        begin
            wrd_reg <= (cmd_reg.in_store && wv_reg[addr]) ? w_mem[addr] : 16'sd0;
            grd_reg <= (cmd_reg.in_store && gv_reg[addr]) ? g_mem[addr] : 32'sd0;
        end
        prod_reg <= prod_next;
    end

    logic w_we, g_we;
    logic signed [15:0] w_wd;
    logic signed [31:0] g_wd;

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[addr] <= w_wd;
        if (g_we)
            g_mem[addr] <= g_wd;
    end

    // operands for the shared 17x32 signed multiplier
    logic signed [16:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [33:0] sum34;
    logic signed [31:0] fsum;
    logic [6:0]         cnt_inc;
    logic [15:0]        a_sig;
    logic [16:0]        a_cmp;

    always_comb
    begin
        mul_a = 17'sd0;
        mul_b = 32'sd0;
        case (cmd_reg.mode)
            tnm_pkg::MODE_FWD:
            begin
                mul_a = 17'(signed'(cmd_reg.value));
                mul_b = 32'(wrd_reg);
            end
            tnm_pkg::MODE_W_GRAD:
            begin
                mul_a = 17'(signed'(cmd_reg.value));
                mul_b = 32'(delta_reg);
            end
            tnm_pkg::MODE_UPD_W:
            begin
                mul_a = signed'({1'b0, rate});
                mul_b = grd_reg;
            end
            tnm_pkg::MODE_UPD_B:
            begin
                mul_a = signed'({1'b0, rate});
                mul_b = bgrad_reg;
            end
            default:
            begin
                mul_a = 17'sd0;
                mul_b = 32'sd0;
            end
        endcase
        prod_next = 48'(mul_a) * 48'(mul_b);
    end

    assign a_sig = tnm_pkg::plan(32'(signed'(cmd_reg.value)) <<< 8);
    assign a_cmp = 17'd256 - {1'b0, a_sig};

    always_comb
    begin
        st_next      = st_reg;
        pop          = 1'b0;
        w_we         = 1'b0;
        g_we         = 1'b0;
        w_wd         = 16'sd0;
        g_wd         = 32'sd0;
        done         = 1'b0;
        kind         = tnm_pkg::KIND_FWD;
        result_value = 16'sd0;
        weighted_sum = 32'sd0;
        size_error   = 1'b0;
        sum34 = (ecnt_reg == 7'd0) ? 34'(bias_reg) <<< 8 : 34'(acc_reg);
        sum34 = sum34 + 34'(prod_reg);
        fsum  = tnm_pkg::sat32(sum34);
        cnt_inc = (ecnt_reg == 7'd127) ? ecnt_reg : ecnt_reg + 7'd1;
        case (st_reg)
            tnm_pkg::BE_IDLE:
                if (!q_stat.empty)
                begin
                    pop     = 1'b1;
                    st_next = tnm_pkg::BE_READ;
                end
            tnm_pkg::BE_READ:
                st_next = tnm_pkg::BE_MUL;
            tnm_pkg::BE_MUL:
                st_next = tnm_pkg::BE_WRITE;
            tnm_pkg::BE_WRITE:
            begin
                st_next = tnm_pkg::BE_IDLE;
                case (cmd_reg.mode)
                    tnm_pkg::MODE_LOAD_W:
                    begin
                        w_we = cmd_reg.in_store;
                        w_wd = cmd_reg.value;
                    end
                    tnm_pkg::MODE_W_GRAD:
                    begin
                        g_we = cmd_reg.in_store;
                        g_wd = tnm_pkg::sat32(34'(grd_reg) + 34'(prod_reg));
                    end
                    tnm_pkg::MODE_UPD_W:
                    begin
                        w_we = cmd_reg.in_store;
                        w_wd = tnm_pkg::sat16(34'(wrd_reg) - 34'(prod_reg >>> 24));
                        g_we = cmd_reg.in_store;
                        g_wd = 32'sd0;
                    end
                    tnm_pkg::MODE_FWD:
                        if (cmd_reg.last)
                        begin
                            done = 1'b1;
                            kind = tnm_pkg::KIND_FWD;
                            if (cnt_inc != in_cnt)
                                size_error = 1'b1;
                            else
                            begin
                                weighted_sum = fsum;
                                if (act_sel)
                                    result_value = signed'(tnm_pkg::plan(fsum));
                                else if (fsum[31])
                                    result_value = 16'sd0;
                                else
                                    result_value = tnm_pkg::sat16(34'(fsum) >>> 8);
                            end
                        end
                    tnm_pkg::MODE_DERIV:
                    begin
                        done = 1'b1;
                        kind = tnm_pkg::KIND_DERIV;
                        if (act_sel)
                            result_value = 16'(({16'd0, a_sig} * {15'd0, a_cmp}) >> 8);
                        else
                            result_value = cmd_reg.value[15] ? 16'sd0 : 16'sd256;
                    end
                    tnm_pkg::MODE_READ_W:
                    begin
                        done         = 1'b1;
                        kind         = tnm_pkg::KIND_READ;
                        result_value = wrd_reg;
                    end
                    default:
                    begin
                        w_we = 1'b0;
                    end
                endcase
            end
            default:
                st_next = tnm_pkg::BE_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= tnm_pkg::BE_IDLE;
            wv_reg    <= '0;
            gv_reg    <= '0;
            bias_reg  <= 16'sd0;
            delta_reg <= 16'sd0;
            bgrad_reg <= 32'sd0;
            acc_reg   <= 32'sd0;
            ecnt_reg  <= 7'd0;
        end
        else
        begin
            st_reg <= st_next;
            if (w_we)
                wv_reg[addr] <= 1'b1;
            if (g_we)
                gv_reg[addr] <= 1'b1;
            if (st_reg == tnm_pkg::BE_WRITE)
            begin
                case (cmd_reg.mode)
                    tnm_pkg::MODE_LOAD_B:
                        bias_reg <= cmd_reg.value;
                    tnm_pkg::MODE_ADD_D:
                        delta_reg <= tnm_pkg::sat16(34'(delta_reg)
                                                    + 34'(signed'(cmd_reg.value)));
                    tnm_pkg::MODE_CLR_D:
                        delta_reg <= 16'sd0;
                    tnm_pkg::MODE_B_GRAD:
                        bgrad_reg <= tnm_pkg::sat32(34'(bgrad_reg)
                                                    + (34'(delta_reg) <<< 8));
                    tnm_pkg::MODE_UPD_B:
                    begin
                        bias_reg  <= tnm_pkg::sat16(34'(bias_reg) - 34'(prod_reg >>> 24));
                        bgrad_reg <= 32'sd0;
                    end
                    tnm_pkg::MODE_FWD:
                    begin
                        if (cmd_reg.last)
                        begin
                            acc_reg  <= 32'sd0;
                            ecnt_reg <= 7'd0;
                        end
                        else
                        begin
                            acc_reg  <= fsum;
                            ecnt_reg <= cnt_inc;
                        end
                    end
                    default:
                        ecnt_reg <= ecnt_reg;
                endcase
            end
        end
    end

endmodule

// ----- hw/rtl/tnm_checker.sv -----
`include "assert_macros.svh"

module tnm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic [1:0]         kind,
    input logic signed [31:0] weighted_sum,
    input logic               size_error,
    input logic               cfg_ready
);

    `ASSERT_IMPL(a_kind_ok, clk, rst_n, result_valid, kind <= 2'(tnm_pkg::KIND_READ), "bad kind")
    `ASSERT_IMPL(a_err_fwd, clk, rst_n, result_valid && size_error, kind == tnm_pkg::KIND_FWD, "err kind")
    `ASSERT_IMPL(a_err_zero, clk, rst_n, result_valid && size_error, weighted_sum == 32'sd0,
                 "err sum")
    `ASSERT_IMPL(a_side_zero, clk, rst_n, result_valid && kind != tnm_pkg::KIND_FWD,
                 weighted_sum == 32'sd0, "sum nonzero")
    `ASSERT_IMPL(a_cfg_rdy, clk, rst_n, 1'b1, cfg_ready, "cfg stall")

endmodule

bind trainable_neuron_mac_top tnm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .result_valid(result_valid), .kind(kind), .weighted_sum(weighted_sum),
    .size_error(size_error), .cfg_ready(cfg_ready)
);

// ----- tb/neuron_result_checker.sv -----
module neuron_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [3:0]         mode,
    input  logic [5:0]         index,
    input  logic signed [15:0] value,
    input  logic               last,
    input  logic               result_valid,
    input  logic [1:0]         kind,
    input  logic signed [15:0] result_value,
    input  logic signed [31:0] weighted_sum,
    input  logic               size_error,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] act;
        logic signed [31:0] wsum;
        logic               err;
    } neuron_word_t;

    neuron_word_t expected_words[$];

    logic signed [15:0] weights [64];
    logic signed [31:0] wgrads  [64];
    logic signed [15:0] bias_q;
    logic signed [31:0] bias_grad;
    logic signed [15:0] delta_q;
    logic signed [31:0] sum_acc;
    int unsigned        elem_cnt;
    logic               act_sel;
    logic [15:0]        rate;
    logic [6:0]         want_cnt;

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // piecewise-linear sigmoid, Q16.16 in, Q8.8 out
    function automatic int sigmoid_q8(logic signed [31:0] x);
        logic [31:0] m;
        logic [31:0] y;
        m = x[31] ? 32'd0 - x : x;
        if (m >= 32'd327680)
            y = 32'd65536;
        else if (m >= 32'd155648)
            y = (m >> 5) + 32'd55296;
        else if (m >= 32'd65536)
            y = (m >> 3) + 32'd40960;
        else
            y = (m >> 2) + 32'd32768;
        if (x[31])
            y = 32'd65536 - y;
        return int'(y >> 8);
    endfunction

    function automatic logic signed [15:0] activate(logic signed [31:0] s);
        if (act_sel)
            return 16'(sigmoid_q8(s));
        if (s < 0)
            return 16'sd0;
        return clip16(longint'(s) >>> 8);
    endfunction

    function automatic logic signed [15:0] stepped(logic signed [15:0] old,
                                                   logic signed [31:0] grad);
        longint d;
        d = (longint'({1'b0, rate}) * longint'(grad)) >>> 24;
        return clip16(longint'(old) - d);
    endfunction

    task automatic predict_word(logic [3:0] m, logic [5:0] i, logic signed [15:0] v,
                                logic l);
        neuron_word_t w;
        longint       acc;
        int           a;
        w = '{kind: tnm_pkg::KIND_FWD, act: 16'sd0, wsum: 32'sd0, err: 1'b0};
        case (m)
            tnm_pkg::MODE_LOAD_W: weights[i] = v;
            tnm_pkg::MODE_LOAD_B: bias_q = v;
            tnm_pkg::MODE_FWD:
            begin
                acc = (elem_cnt == 0) ? longint'(bias_q) * 256 : longint'(sum_acc);
                acc += longint'(v) * longint'(weights[i]);
                sum_acc = clip32(acc);
                if (elem_cnt < 127)
                    elem_cnt++;
                if (l)
                begin
                    if (elem_cnt != want_cnt)
                        w.err = 1'b1;
                    else
                    begin
                        w.wsum = sum_acc;
                        w.act  = activate(sum_acc);
                    end
                    sum_acc  = 32'sd0;
                    elem_cnt = 0;
                    expected_words.insert(expected_words.size(), w);
                end
            end
            tnm_pkg::MODE_ADD_D:  delta_q = clip16(longint'(delta_q) + longint'(v));
            tnm_pkg::MODE_CLR_D:  delta_q = 16'sd0;
            tnm_pkg::MODE_W_GRAD: wgrads[i] = clip32(longint'(wgrads[i])
                                                     + longint'(v) * longint'(delta_q));
            tnm_pkg::MODE_B_GRAD: bias_grad = clip32(longint'(bias_grad)
                                                     + longint'(delta_q) * 256);
            tnm_pkg::MODE_UPD_W:
            begin
                weights[i] = stepped(weights[i], wgrads[i]);
                wgrads[i]  = 32'sd0;
            end
            tnm_pkg::MODE_UPD_B:
            begin
                bias_q    = stepped(bias_q, bias_grad);
                bias_grad = 32'sd0;
            end
            tnm_pkg::MODE_DERIV:
            begin
                w.kind = tnm_pkg::KIND_DERIV;
                if (act_sel)
                begin
                    a = sigmoid_q8(32'(int'(v) * 256));
                    w.act = 16'((a * (256 - a)) >> 8);
                end
                else
                    w.act = (v < 0) ? 16'sd0 : 16'sd256;
                expected_words.insert(expected_words.size(), w);
            end
            tnm_pkg::MODE_READ_W:
            begin
                w.kind = tnm_pkg::KIND_READ;
                w.act  = weights[i];
                expected_words.insert(expected_words.size(), w);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        neuron_word_t exp_w;
        if (!rst_n)
        begin
            for (int k = 0; k < 64; k++)
            begin
                weights[k] = 16'sd0;
                wgrads[k]  = 32'sd0;
            end
            bias_q     = 16'sd0;
            bias_grad  = 32'sd0;
            delta_q    = 16'sd0;
            sum_acc    = 32'sd0;
            elem_cnt   = 0;
            act_sel    = 1'b0;
            rate       = 16'd655;
            want_cnt   = 7'd64;
            mismatches = 0;
            expected_words.delete();
        end
        else
        begin
            // results come from earlier words, so check before predicting
            if (result_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: kind %0d value %0d sum %0d err %0b",
                                 kind, result_value, weighted_sum, size_error);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (kind !== exp_w.kind || result_value !== exp_w.act
                        || weighted_sum !== exp_w.wsum || size_error !== exp_w.err)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: exp kind %0d value %0d sum %0d err %0b,",
                                      " got kind %0d value %0d sum %0d err %0b"},
                                     exp_w.kind, exp_w.act, exp_w.wsum, exp_w.err,
                                     kind, result_value, weighted_sum, size_error);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tnm_pkg::CFG_ACT:  act_sel  = cfg_data[0];
                    tnm_pkg::CFG_RATE: rate     = cfg_data;
                    tnm_pkg::CFG_CNT:  want_cnt = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_word(mode, index, value, last);
        end
        outstanding = expected_words.size();
    end

endmodule

// ----- tb/trainable_neuron_mac_top_tb.sv -----
module trainable_neuron_mac_top_tb;

    localparam int STALL_LIMIT = 5000;   // cycles without any handshake
    localparam int DRAIN_WAIT  = 40;     // outlasts the drain of 3 words in flight

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         mode;
    logic [5:0]         index;
    logic signed [15:0] value;
    logic               last;
    logic               result_valid;
    logic [1:0]         kind;
    logic signed [15:0] result_value;
    logic signed [31:0] weighted_sum;
    logic               size_error;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    int mismatches;
    int outstanding;
    int stall_cycles;
    int sent_words;
    int cur_count;      // tb copy of input_count, shapes the passes

    trainable_neuron_mac_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .index        (index),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .kind         (kind),
        .result_value (result_value),
        .weighted_sum (weighted_sum),
        .size_error   (size_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    neuron_result_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .index        (index),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .kind         (kind),
        .result_value (result_value),
        .weighted_sum (weighted_sum),
        .size_error   (size_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // watchdog: any accepted word on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("trainable_neuron_mac_top regression: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Q8.8 operand: mostly small, sometimes full range or a rail
    function automatic logic signed [15:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'($urandom);
        if (r == 1)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return 16'($signed($urandom_range(0, 2048)) - 1024);
    endfunction

    // one command word; start stays high across back-to-back words
    task automatic send_word(logic [3:0] m, logic [5:0] i, logic signed [15:0] v, logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        mode  <= m;
        index <= i;
        value <= v;
        last  <= l;
        do @(posedge clk); while (busy);
        @(negedge clk);
        sent_words++;
    endtask

    // block is idle once nothing is expected and the back end has drained
    task automatic write_reg(logic [1:0] ri, logic [15:0] d);
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (ri == tnm_pkg::CFG_CNT)
            cur_count = d[6:0];
    endtask

    task automatic setup(logic act, logic [15:0] lr, logic [6:0] cnt);
        write_reg(tnm_pkg::CFG_ACT, {15'd0, act});
        write_reg(tnm_pkg::CFG_RATE, lr);
        write_reg(tnm_pkg::CFG_CNT, {9'd0, cnt});
    endtask

    // any non-forward word, unused modes included
    task automatic send_side_op();
        int r;
        logic [3:0] m;
        r = $urandom_range(0, 11);
        case (r)
            0:  m = tnm_pkg::MODE_LOAD_W;
            1:  m = tnm_pkg::MODE_LOAD_B;
            2:  m = tnm_pkg::MODE_ADD_D;
            3:  m = tnm_pkg::MODE_CLR_D;
            4:  m = tnm_pkg::MODE_W_GRAD;
            5:  m = tnm_pkg::MODE_B_GRAD;
            6:  m = tnm_pkg::MODE_UPD_W;
            7:  m = tnm_pkg::MODE_UPD_B;
            8:  m = tnm_pkg::MODE_DERIV;
            9:  m = tnm_pkg::MODE_READ_W;
            10: m = tnm_pkg::MODE_LOAD_W;
            default: m = tnm_pkg::MODE_NOP - 4'($urandom_range(0, 4));
        endcase
        send_word(m, 6'($urandom), pick_value(), 1'($urandom));
    endtask

    // forward pass of len words, with a side op slipped in now and then
    task automatic send_pass(int len);
        for (int e = 0; e < len; e++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_side_op();
            send_word(tnm_pkg::MODE_FWD, 6'($urandom), pick_value(), e == len - 1);
        end
    endtask

    task automatic random_phase(int budget);
        int len;
        int start_cnt;
        start_cnt = sent_words;
        while (sent_words - start_cnt < budget)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                if (cur_count == 0 || $urandom_range(0, 6) == 0)
                    len = $urandom_range(1, (cur_count > 0 ? cur_count : 2) + 2);
                else
                    len = cur_count;
                send_pass(len);
            end
            else
                send_side_op();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = tnm_pkg::MODE_NOP;
        index      = 6'd0;
        value      = 16'sd0;
        last       = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = tnm_pkg::CFG_ACT;
        cfg_data   = 16'd0;
        sent_words = 0;
        cur_count  = 64;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: rails, saturation, every mode, size errors, unused modes
        setup(1'b0, 16'd655, 7'd3);
        send_word(tnm_pkg::MODE_LOAD_W, 6'd0, 16'sh7fff, 1'b0);
        send_word(tnm_pkg::MODE_LOAD_W, 6'd1, 16'sh8000, 1'b0);
        send_word(tnm_pkg::MODE_LOAD_W, 6'd63, -16'sd1, 1'b0);
        send_word(tnm_pkg::MODE_LOAD_B, 6'd0, 16'sh7fff, 1'b0);
        send_word(tnm_pkg::MODE_FWD, 6'd0, 16'sh7fff, 1'b0);
        send_word(tnm_pkg::MODE_READ_W, 6'd63, 16'sd0, 1'b0);   // interleaved mid-pass
        send_word(tnm_pkg::MODE_FWD, 6'd1, 16'sh8000, 1'b0);
        send_word(tnm_pkg::MODE_FWD, 6'd0, 16'sh7fff, 1'b1);
        send_word(tnm_pkg::MODE_FWD, 6'd1, 16'sh7fff, 1'b0);    // short pass
        send_word(tnm_pkg::MODE_FWD, 6'd1, 16'sh7fff, 1'b1);
        send_pass(4);                                           // long pass
        send_word(tnm_pkg::MODE_DERIV, 6'd0, -16'sd1, 1'b0);
        send_word(tnm_pkg::MODE_DERIV, 6'd0, 16'sd0, 1'b0);
        send_word(tnm_pkg::MODE_ADD_D, 6'd0, 16'sh7fff, 1'b0);
        send_word(tnm_pkg::MODE_ADD_D, 6'd0, 16'sh7fff, 1'b0);  // delta saturates
        send_word(tnm_pkg::MODE_W_GRAD, 6'd0, 16'sh7fff, 1'b0);
        send_word(tnm_pkg::MODE_B_GRAD, 6'd0, 16'sd0, 1'b0);
        send_word(tnm_pkg::MODE_UPD_W, 6'd0, 16'sd0, 1'b0);
        send_word(tnm_pkg::MODE_UPD_B, 6'd0, 16'sd0, 1'b0);
        send_word(tnm_pkg::MODE_READ_W, 6'd0, 16'sd0, 1'b0);
        send_word(tnm_pkg::MODE_CLR_D, 6'd0, 16'sd0, 1'b1);
        send_word(4'(tnm_pkg::MODE_READ_W) + 4'd1, 6'd5, 16'sd9, 1'b1);
        send_word(tnm_pkg::MODE_NOP, 6'd63, 16'sh8000, 1'b1);

        // sweep settings, rails included; index 3 is an unused register
        random_phase(70);
        setup(1'b1, 16'hffff, 7'd1);
        write_reg(2'd3, 16'hffff);
        random_phase(80);
        setup(1'b0, 16'd0, 7'd64);
        random_phase(90);
        setup(1'b1, 16'($urandom), 7'($urandom_range(2, 8)));
        random_phase(70);
        setup(1'b0, 16'($urandom), 7'd5);
        random_phase(60);
        setup(1'b1, 16'd1, 7'd127);                    // count tops out at 127
        send_pass(127);
        send_pass(130);
        random_phase(20);
        setup(1'b0, 16'($urandom), 7'd0);              // every pass mismatches
        random_phase(40);
        setup(1'b1, 16'($urandom), 7'($urandom_range(1, 6)));
        random_phase(60);

        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("trainable_neuron_mac_top regression: pass");
        else
            $display("trainable_neuron_mac_top regression: fail");
        $finish;
    end

endmodule
